/* rtl/mlr_pkg.sv */
// shared constants and types for the midpoint line rasterizer
package mlr_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // command codes
    typedef logic t_cmd;
    localparam t_cmd CMD_START = 1'b0;
    localparam t_cmd CMD_STEP  = 1'b1;

    // line classes
    typedef logic [1:0] t_octant;
    localparam t_octant OCT_SHALLOW_RISE = 2'd0;
    localparam t_octant OCT_SHALLOW_FALL = 2'd1;
    localparam t_octant OCT_STEEP_RISE   = 2'd2;
    localparam t_octant OCT_STEEP_FALL   = 2'd3;

endpackage

/* rtl/midpoint_line_rasterizer_unit.sv */
// Midpoint line rasterizer, all octants. A start item loads two endpoints and
// returns the first pixel; each step item returns the next pixel, flagging
// the far endpoint with last_pixel, or an invalid all-zero pixel when no
// line is running. One item is taken per clock cycle, sustained, while the
// output is not stalled. Each item is captured in the input register, then
// passes the add/compare of the line core, which updates the line state on
// the same edge that loads the output register. The rate is set by the line
// core's state update, computed combinationally and registered per item, which
// lets each step follow the previous one directly.
module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mlr_pkg::t_cmd         i_command,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_pixel_valid,
    output logic                  o_last_pixel
);
    import mlr_pkg::*;

    // input register
    logic                  r_in_valid;
    t_cmd                  r_cmd;
    logic [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;

    // output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                  r_pv, r_last;

    // core result
    logic [COORD_BITS-1:0] c_px, c_py;
    logic                  c_pv, c_last;

    logic fire;

    // an item moves through the core when the output slot frees up
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_command;
            r_sx  <= i_start_x;
            r_sy  <= i_start_y;
            r_ex  <= i_end_x;
            r_ey  <= i_end_y;
        end
    end

    // line state and step logic
    mlr_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (fire),
        .i_command    (r_cmd),
        .i_start_x    (r_sx),
        .i_start_y    (r_sy),
        .i_end_x      (r_ex),
        .i_end_y      (r_ey),
        .o_pixel_x    (c_px),
        .o_pixel_y    (c_py),
        .o_pixel_valid(c_pv),
        .o_last_pixel (c_last)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_px   <= c_px;
            r_py   <= c_py;
            r_pv   <= c_pv;
            r_last <= c_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_valid = r_pv;
    assign o_last_pixel  = r_last;

endmodule

/* rtl/mlr_core.sv */
// line state registers and combinational start/step datapath
module mlr_core #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  mlr_pkg::t_cmd         i_command,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_pixel_valid,
    output logic                  o_last_pixel
);
    import mlr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DB = COORD_BITS + 3;

    // line state
    logic [CB-1:0]        r_cx, r_cy, r_tx, r_ty;
    logic [CB-1:0]        n_cx, n_cy, n_tx, n_ty;
    logic signed [DB-1:0] r_dec, n_dec;
    logic signed [CB:0]   r_dy, n_dy, r_ndx, n_ndx;
    t_octant              r_oct, n_oct;
    logic                 r_busy, n_busy;

    // start arithmetic
    logic                 swap;
    logic [CB-1:0]        x0, y0, x1, y1;
    logic signed [CB:0]   sa, sb, mag_a, mag_b;
    logic signed [DB-1:0] sae, sbe;
    logic                 steep;

    // step arithmetic
    logic signed [DB-1:0] ae, be, sum_ab, dif_ab, sum2, dif2, a2, b2;
    logic                 le0;
    logic                 at_end;
    logic [CB-1:0]        one;

    assign one = {{(CB-1){1'b0}}, 1'b1};

    // endpoint ordering and classification
    assign swap  = i_start_x > i_end_x;
    assign x0    = swap ? i_end_x   : i_start_x;
    assign y0    = swap ? i_end_y   : i_start_y;
    assign x1    = swap ? i_start_x : i_end_x;
    assign y1    = swap ? i_start_y : i_end_y;
    assign sa    = $signed({1'b0, y1}) - $signed({1'b0, y0});
    assign sb    = $signed({1'b0, x0}) - $signed({1'b0, x1});
    assign mag_a = sa[CB] ? -sa : sa;
    assign mag_b = -sb;
    assign steep = mag_a > mag_b;
    assign sae   = {{2{sa[CB]}}, sa};
    assign sbe   = {{2{sb[CB]}}, sb};

    // step increments from the stored deltas
    assign ae     = {{2{r_dy[CB]}}, r_dy};
    assign be     = {{2{r_ndx[CB]}}, r_ndx};
    assign sum_ab = ae + be;
    assign dif_ab = ae - be;
    assign sum2   = {sum_ab[DB-2:0], 1'b0};
    assign dif2   = {dif_ab[DB-2:0], 1'b0};
    assign a2     = {ae[DB-2:0], 1'b0};
    assign b2     = {be[DB-2:0], 1'b0};
    assign le0    = r_dec[DB-1] || (r_dec == '0);

    // end test on the next position
    assign at_end = (n_oct == OCT_SHALLOW_RISE || n_oct == OCT_SHALLOW_FALL)
                    ? (n_cx == n_tx) : (n_cy == n_ty);

    // next state and emitted pixel
    always_comb begin
        n_cx  = r_cx;
        n_cy  = r_cy;
        n_tx  = r_tx;
        n_ty  = r_ty;
        n_dec = r_dec;
        n_dy  = r_dy;
        n_ndx = r_ndx;
        n_oct = r_oct;
        n_busy = r_busy;
        o_pixel_x = '0;
        o_pixel_y = '0;
        o_pixel_valid = 1'b0;
        o_last_pixel = 1'b0;
        if (i_command == CMD_START) begin
            n_cx  = x0;
            n_cy  = y0;
            n_tx  = x1;
            n_ty  = y1;
            n_dy  = sa;
            n_ndx = sb;
            if (!steep && !sa[CB]) begin
                n_oct = OCT_SHALLOW_RISE;
                n_dec = {sae[DB-2:0], 1'b0} + sbe;
            end else if (!steep) begin
                n_oct = OCT_SHALLOW_FALL;
                n_dec = {sae[DB-2:0], 1'b0} - sbe;
            end else if (!sa[CB]) begin
                n_oct = OCT_STEEP_RISE;
                n_dec = {sbe[DB-2:0], 1'b0} + sae;
            end else begin
                n_oct = OCT_STEEP_FALL;
                n_dec = sae - {sbe[DB-2:0], 1'b0};
            end
        end else if (r_busy) begin
            unique case (r_oct)
                OCT_SHALLOW_RISE: begin
                    n_cx = r_cx + one;
                    if (le0) begin
                        n_dec = r_dec + a2;
                    end else begin
                        n_cy  = r_cy + one;
                        n_dec = r_dec + sum2;
                    end
                end
                OCT_SHALLOW_FALL: begin
                    n_cx = r_cx + one;
                    if (le0) begin
                        n_cy  = r_cy - one;
                        n_dec = r_dec + dif2;
                    end else begin
                        n_dec = r_dec + a2;
                    end
                end
                OCT_STEEP_RISE: begin
                    n_cy = r_cy + one;
                    if (le0) begin
                        n_cx  = r_cx + one;
                        n_dec = r_dec + sum2;
                    end else begin
                        n_dec = r_dec + b2;
                    end
                end
                default: begin
                    n_cy = r_cy - one;
                    if (le0) begin
                        n_dec = r_dec - b2;
                    end else begin
                        n_cx  = r_cx + one;
                        n_dec = r_dec + dif2;
                    end
                end
            endcase
        end
        // a pixel goes out on a start or a busy step
        if (i_command == CMD_START || r_busy) begin
            n_busy        = !at_end;
            o_pixel_x     = n_cx;
            o_pixel_y     = n_cy;
            o_pixel_valid = 1'b1;
            o_last_pixel  = at_end;
        end
    end

    // state update on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_tx   <= '0;
            r_ty   <= '0;
            r_dec  <= '0;
            r_dy   <= '0;
            r_ndx  <= '0;
            r_oct  <= OCT_SHALLOW_RISE;
            r_busy <= 1'b0;
        end else if (i_en) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_tx   <= n_tx;
            r_ty   <= n_ty;
            r_dec  <= n_dec;
            r_dy   <= n_dy;
            r_ndx  <= n_ndx;
            r_oct  <= n_oct;
            r_busy <= n_busy;
        end
    end

endmodule

/* rtl/mlr_checker.sv */
// port-level checks for the midpoint line rasterizer, bound to the top level
module mlr_port_checks #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input mlr_pkg::t_cmd         i_command,
    input logic [COORD_BITS-1:0] i_start_x,
    input logic [COORD_BITS-1:0] i_start_y,
    input logic [COORD_BITS-1:0] i_end_x,
    input logic [COORD_BITS-1:0] i_end_y,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_pixel_valid,
    input logic                  o_last_pixel
);
    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_pixel_valid) && $stable(o_last_pixel))
        else $error("result item changed while stalled");

    // an idle step reports an all-zero pixel
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_valid |->
            !o_last_pixel && o_pixel_x == '0 && o_pixel_y == '0)
        else $error("idle step carries pixel data");

    // no result item right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item present after reset");

    // an empty output slot never blocks the input side
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind midpoint_line_rasterizer_unit mlr_port_checks #(
    .COORD_BITS(COORD_BITS)
) u_mlr_checker (.*);
